>>> rtl/wis_pkg.sv
// Shared types and constants for the weighted index sampler.
// No dependencies; imported by every module and interface of the block.
package wis_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = 4;    // entry_index / chosen_index width
   localparam int WEIGHT_W    = 16;   // Q0.16 weight and random value
   localparam int CNT_W       = 5;    // entries_in_use width
   localparam int SUM_W       = 20;   // exact running sum of 16 weights

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_DRAW  = 1'b1;

   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_ENTRIES);

   typedef enum logic {
      ST_IDLE,
      ST_STEP
   } wis_state_type;

   typedef struct packed {
      logic load;      // take the input item into the work registers
      logic advance;   // add current weight, move to next entry
      logic finish;    // load result register (and commit a write)
   } wis_cmd_type;

   typedef struct packed {
      logic is_draw;   // current item is a draw
      logic hit;       // draw stops at the current entry
      logic out_free;  // result register can take a new result
   } wis_status_type;

endpackage

>>> rtl/wis_req_if.sv
// Request channel: valid/ready with one sampler input item.
// Depends on wis_pkg.
interface wis_req_if;
   import wis_pkg::*;

   logic                valid;
   logic                ready;
   logic                func;
   logic [IDX_W-1:0]    entry_index;
   logic [WEIGHT_W-1:0] weight;
   logic [WEIGHT_W-1:0] random_value;

   modport source (output valid, func, entry_index, weight, random_value, input ready);
   modport sink   (input valid, func, entry_index, weight, random_value, output ready);
endinterface

>>> rtl/wis_rsp_if.sv
// Response channel: valid/ready with one sampler result item.
// Depends on wis_pkg.
interface wis_rsp_if;
   import wis_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] chosen_index;
   logic             is_draw;

   modport source (output valid, chosen_index, is_draw, input ready);
   modport sink   (input valid, chosen_index, is_draw, output ready);
endinterface

>>> rtl/wis_csr_if.sv
// Configuration write channel: valid/ready with the entry count.
// Depends on wis_pkg.
interface wis_csr_if;
   import wis_pkg::*;

   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] entries_in_use;

   modport source (output valid, entries_in_use, input ready);
   modport sink   (input valid, entries_in_use, output ready);
endinterface

>>> rtl/weighted_index_sampler.sv
// Weighted index sampler (roulette wheel) over 16 Q0.16 weights.
// A write goes through load and the step state to its response; a draw walks the table
// from entry zero, adding each passed weight to the 20-bit running sum, to its stop.
// One item at a time: the next is accepted once the controller is back in idle after the
// result registers, and it holds in its step state while the previous one is unclaimed.
// Reset (synchronous, active high): all weights zero, entry count 16, no result pending.
module weighted_index_sampler (
   input logic clock,
   input logic reset,
   wis_req_if.sink   req,
   wis_rsp_if.source rsp,
   wis_csr_if.sink   csr
);
   import wis_pkg::*;

   wis_cmd_type    cmd;
   wis_status_type status;
   logic           req_ready;

   assign req.ready = req_ready;
   assign csr.ready = 1'b1;

   wis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wis_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req.func),
      .req_entry_index  (req.entry_index),
      .req_weight       (req.weight),
      .req_random_value (req.random_value),
      .csr_write        (csr.valid && csr.ready),
      .csr_data         (csr.entries_in_use),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_chosen_index (rsp.chosen_index),
      .rsp_is_draw      (rsp.is_draw)
   );

   // busy right after a transfer in
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while an item is in flight");

   // a finished item always shows up on the response side
   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp.valid)
      else $error("finished item not presented as a response");

   // write acknowledges carry index zero
   a_write_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.is_draw |-> rsp.chosen_index == '0)
      else $error("write acknowledge with nonzero index");

   // never overwrite a pending result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp.valid || rsp.ready)
      else $error("result register overwritten before transfer");
endmodule

>>> rtl/wis_ctrl.sv
// Sampler controller: two-state FSM sequencing load, walk and result hand-off.
// Depends on wis_pkg (state, command and status types).
module wis_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wis_pkg::wis_status_type status,
   output wis_pkg::wis_cmd_type    cmd
);
   import wis_pkg::*;

   wis_state_type state_ff, state_in;
   logic          done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      done      = !status.is_draw || status.hit;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (done) begin
               // hold here while the previous result is still unclaimed
               if (status.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

>>> rtl/wis_datapath.sv
// Sampler datapath: weight table, count register, running sum, walk index
// and result register. Depends on wis_pkg.
module wis_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  wis_pkg::wis_cmd_type         cmd,
   output wis_pkg::wis_status_type      status,
   input  logic                         req_func,
   input  logic [wis_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [wis_pkg::WEIGHT_W-1:0] req_weight,
   input  logic [wis_pkg::WEIGHT_W-1:0] req_random_value,
   input  logic                         csr_write,
   input  logic [wis_pkg::CNT_W-1:0]    csr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [wis_pkg::IDX_W-1:0]    rsp_chosen_index,
   output logic                         rsp_is_draw
);
   import wis_pkg::*;

   logic [WEIGHT_W-1:0] weight_ff [MAX_ENTRIES];
   logic [CNT_W-1:0]    count_ff;
   logic                func_ff;
   logic [IDX_W-1:0]    idx_ff;      // walk index, or write slot for a write
   logic [IDX_W-1:0]    last_ff;     // effective count minus one
   logic [WEIGHT_W-1:0] wdata_ff;
   logic [WEIGHT_W-1:0] rand_ff;
   logic [SUM_W-1:0]    acc_ff;
   logic                out_valid_ff;
   logic [IDX_W-1:0]    out_index_ff;
   logic                out_draw_ff;

   logic [IDX_W-1:0]    last_in;
   logic [SUM_W-1:0]    upper;
   logic [WEIGHT_W-1:0] cur_weight;

   // zero counts as one entry, counts past the table saturate
   always_comb begin
      if (count_ff == '0) begin
         last_in = '0;
      end else if (count_ff > CNT_W'(MAX_ENTRIES)) begin
         last_in = IDX_W'(MAX_ENTRIES - 1);
      end else begin
         last_in = IDX_W'(count_ff - CNT_W'(1));
      end
   end

   assign cur_weight = weight_ff[idx_ff];
   assign upper      = acc_ff + SUM_W'(cur_weight);

   assign status.is_draw  = (func_ff == FUNC_DRAW);
   assign status.hit      = (SUM_W'(rand_ff) < upper) || (idx_ff == last_ff);
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_RESET;
         for (int k = 0; k < MAX_ENTRIES; k++) begin
            weight_ff[k] <= '0;
         end
      end else begin
         if (csr_write) begin
            count_ff <= csr_data;
         end
         if (cmd.finish && func_ff == FUNC_WRITE) begin
            weight_ff[idx_ff] <= wdata_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         idx_ff   <= (req_func == FUNC_DRAW) ? '0 : req_entry_index;
         last_ff  <= last_in;
         wdata_ff <= req_weight;
         rand_ff  <= req_random_value;
         acc_ff   <= '0;
      end else if (cmd.advance) begin
         acc_ff <= upper;
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_index_ff <= (func_ff == FUNC_DRAW) ? idx_ff : '0;
         out_draw_ff  <= (func_ff == FUNC_DRAW);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_chosen_index = out_index_ff;
   assign rsp_is_draw      = out_draw_ff;
endmodule

>>> tb/weighted_index_sampler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for weighted_index_sampler: random valid/ready traffic on
// the request and response channels, csr writes, checked by an in-order scoreboard.
// Depends on wis_pkg, wis_req_if, wis_rsp_if, wis_csr_if and the sampler RTL.
module weighted_index_sampler_tb;
   import wis_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASES       = 12;
   localparam int DRAWS_IN_MIX = 104;

   typedef struct packed {
      logic [IDX_W-1:0] chosen_index;
      logic             is_draw;
   } sample_type;

   typedef enum int {
      PROFILE_SPREAD,
      PROFILE_SPARSE,
      PROFILE_FULL,
      PROFILE_TINY
   } weight_profile_type;

   // Tracks the weight table and entry count, predicts each response in order.
   class sampler_scoreboard_type;
      logic [WEIGHT_W-1:0] weights [MAX_ENTRIES];
      logic [CNT_W-1:0]    entry_count;
      sample_type          pending [$];
      int                  errors;

      function new();
         foreach (weights[i]) weights[i] = '0;
         entry_count = CNT_RESET;
         errors = 0;
      endfunction

      function void set_count(logic [CNT_W-1:0] value);
         entry_count = value;
      endfunction

      // zero acts as one, anything past the table saturates
      function int active_entries();
         if (entry_count == 0) return 1;
         if (entry_count > MAX_ENTRIES) return MAX_ENTRIES;
         return int'(entry_count);
      endfunction

      // sum of the weights a draw can stop on (all but the last active entry)
      function int unsigned span();
         int unsigned total;
         total = 0;
         for (int i = 0; i + 1 < active_entries(); i++) total += weights[i];
         return total;
      endfunction

      function logic [IDX_W-1:0] pick_index(logic [WEIGHT_W-1:0] r);
         int               n;
         logic [SUM_W-1:0] acc;
         n = active_entries();
         acc = '0;
         for (int i = 0; i + 1 < n; i++) begin
            if (SUM_W'(r) < acc + SUM_W'(weights[i])) return IDX_W'(i);
            acc = acc + SUM_W'(weights[i]);
         end
         return IDX_W'(n - 1);
      endfunction

      function void note_request(logic func, logic [IDX_W-1:0] idx,
                                 logic [WEIGHT_W-1:0] w, logic [WEIGHT_W-1:0] r);
         sample_type s;
         if (func == FUNC_WRITE) begin
            weights[idx] = w;
            s.chosen_index = '0;
            s.is_draw = 1'b0;
         end else begin
            s.chosen_index = pick_index(r);
            s.is_draw = 1'b1;
         end
         pending.push_back(s);
      endfunction

      function void check_response(logic [IDX_W-1:0] idx, logic is_draw);
         sample_type s;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected response: index %0d draw %0b", $realtime, idx, is_draw);
            return;
         end
         s = pending.pop_front();
         if (idx !== s.chosen_index || is_draw !== s.is_draw) begin
            errors++;
            if (errors <= 10)
               $display("%0t: mismatch: expected index %0d draw %0b, got index %0d draw %0b",
                        $realtime, s.chosen_index, s.is_draw, idx, is_draw);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   req_calm = 1'b0;
   bit   rsp_calm = 1'b0;
   int   quiet_cycles = 0;

   sampler_scoreboard_type sb = new();

   wis_req_if req ();
   wis_rsp_if rsp ();
   wis_csr_if csr ();

   weighted_index_sampler dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transfer monitors
   always @(posedge clock) begin
      if (!reset && req.valid === 1'b1 && req.ready === 1'b1)
         sb.note_request(req.func, req.entry_index, req.weight, req.random_value);
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1)
         sb.check_response(rsp.chosen_index, rsp.is_draw);
      if (!reset && csr.valid === 1'b1 && csr.ready === 1'b1)
         sb.set_count(csr.entries_in_use);
   end

   always @(posedge clock) begin
      if (reset || (req.valid === 1'b1 && req.ready === 1'b1)
                || (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                || (csr.valid === 1'b1 && csr.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic int pick_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight(weight_profile_type profile, int n);
      int lim;
      case (profile)
         PROFILE_SPREAD: begin
            lim = 131072 / n;
            if (lim > 65535) lim = 65535;
            return WEIGHT_W'($urandom_range(0, lim));
         end
         PROFILE_SPARSE: return ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom) : '0;
         PROFILE_FULL:   return WEIGHT_W'($urandom);
         default:        return WEIGHT_W'($urandom_range(0, 64));
      endcase
   endfunction

   // half full-range, half inside the reachable sum so draws land on middle entries
   function automatic logic [WEIGHT_W-1:0] pick_draw_value();
      int unsigned top;
      top = sb.span();
      if (top > 65535) top = 65535;
      if ($urandom_range(0, 1) == 0) return WEIGHT_W'($urandom);
      return WEIGHT_W'($urandom_range(0, top));
   endfunction

   task automatic send_item(logic func, logic [IDX_W-1:0] idx,
                            logic [WEIGHT_W-1:0] w, logic [WEIGHT_W-1:0] r);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         @(negedge clock);
         req.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req.valid        <= 1'b1;
      req.func         <= func;
      req.entry_index  <= idx;
      req.weight       <= w;
      req.random_value <= r;
      do @(posedge clock); while (!(req.valid === 1'b1 && req.ready === 1'b1));
   endtask

   task automatic write_weight(logic [IDX_W-1:0] idx, logic [WEIGHT_W-1:0] w);
      send_item(FUNC_WRITE, idx, w, WEIGHT_W'($urandom));
   endtask

   task automatic draw(logic [WEIGHT_W-1:0] r);
      send_item(FUNC_DRAW, IDX_W'($urandom), WEIGHT_W'($urandom), r);
   endtask

   // stop sending and wait until every response is back
   task automatic settle();
      @(negedge clock);
      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic set_entries(logic [CNT_W-1:0] value);
      settle();
      @(negedge clock);
      csr.valid          <= 1'b1;
      csr.entries_in_use <= value;
      do @(posedge clock); while (!(csr.valid === 1'b1 && csr.ready === 1'b1));
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   // response side
   initial begin
      int stall;
      rsp.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      rsp.ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp.valid === 1'b1 && rsp.ready === 1'b1));
         stall = pick_gap(rsp_calm);
         if (stall > 0) begin
            @(negedge clock);
            rsp.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
            @(negedge clock);
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      int                 phase_counts [PHASES] = '{16, 1, 0, 2, 31, 17, 8, 4, 16, 3, 12, 16};
      logic [CNT_W-1:0]   cnt;
      weight_profile_type profile;

      reset              = 1'b1;
      req.valid          = 1'b0;
      req.func           = FUNC_WRITE;
      req.entry_index    = '0;
      req.weight         = '0;
      req.random_value   = '0;
      csr.valid          = 1'b0;
      csr.entries_in_use = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table first: a draw falls through to the last entry until weights are written
      draw(16'h0000);
      draw(16'hFFFF);
      write_weight(IDX_W'(0), 16'hFFFF);
      draw(16'hFFFE);
      draw(16'hFFFF);
      write_weight(IDX_W'(1), 16'h0001);
      draw(16'hFFFF);
      write_weight(IDX_W'(15), 16'hFFFF);
      write_weight(IDX_W'(7), 16'h5555);
      write_weight(IDX_W'(8), 16'hAAAA);
      draw(16'h0000);
      write_weight(IDX_W'(0), 16'h0000);
      draw(16'h0000);

      // zero count behaves as one entry
      set_entries(CNT_W'(0));
      draw(16'hFFFF);
      // counts past the table saturate
      set_entries(CNT_W'(31));
      draw(16'hFFFF);
      set_entries(CNT_W'(17));
      draw(16'h8000);
      set_entries(CNT_W'(1));
      draw(16'h0000);
      set_entries(CNT_W'(2));
      draw(16'hFFFF);
      draw(16'h0000);

      for (int ph = 0; ph < PHASES; ph++) begin
         cnt = (ph == 7) ? CNT_W'($urandom_range(0, 31)) : CNT_W'(phase_counts[ph]);
         set_entries(cnt);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         profile  = weight_profile_type'($urandom_range(0, 3));
         for (int k = 0; k < MAX_ENTRIES; k++)
            write_weight(IDX_W'(k), pick_weight(profile, sb.active_entries()));
         for (int k = 0; k < DRAWS_IN_MIX; k++) begin
            if ($urandom_range(0, 4) == 0)
               write_weight(IDX_W'($urandom), pick_weight(profile, sb.active_entries()));
            else
               draw(pick_draw_value());
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
rtl/wis_pkg.sv
rtl/wis_req_if.sv
rtl/wis_rsp_if.sv
rtl/wis_csr_if.sv
rtl/wis_ctrl.sv
rtl/wis_datapath.sv
rtl/weighted_index_sampler.sv
tb/weighted_index_sampler_tb.sv
